[rtl/alm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alm_pkg: shared types and constants of the alarm table and countdown timer
// Holds the command codes, sequencer states, entry layout and the request and
// response structures of the shared arithmetic unit.
// ----------------------------------------------------------------------------
package alm_pkg;

    typedef enum logic [3:0] {
        CMD_TICK       = 4'd0,
        CMD_ADD        = 4'd1,
        CMD_TOGGLE     = 4'd2,
        CMD_DELETE     = 4'd3,
        CMD_STOP_RING  = 4'd4,
        CMD_TIMER_TGL  = 4'd5,
        CMD_TIMER_RST  = 4'd6,
        CMD_PLUS_MIN   = 4'd7,
        CMD_MINUS_MIN  = 4'd8
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_RING_CHK,
        S_TMR_AGE,
        S_TMR_CHK,
        S_WALK,
        S_TOGGLE_WR,
        S_DELETE,
        S_DONE
    } state_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t     op;
        logic [31:0] a;
        logic [31:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [31:0] res;
        logic        carry;   // carry out on add, borrow on subtract
        logic        zero;
    } alu_rsp_t;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic       enabled;
        logic       latched;
    } entry_t;

    localparam logic [31:0] RING_TIMEOUT = 32'd300;
    localparam logic [15:0] STEP_SECONDS = 16'd60;
    localparam logic [15:0] DUR_RESET    = 16'd60;
    localparam logic [15:0] DUR_MAX      = 16'hFFFF;

endpackage

[rtl/alm_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alm_alu: shared add/subtract unit
// One 32-bit adder used by the sequencer for tick ages, limit and timeout
// compares, duration steps and the hour/minute match of each alarm entry.
// ----------------------------------------------------------------------------
module alm_alu
(
    input  alm_pkg::alu_req_t req,
    output alm_pkg::alu_rsp_t rsp
);

    logic [32:0] sum;

    always_comb
    begin
        if (req.op == alm_pkg::ALU_SUB)
        begin
            sum = {1'b0, req.a} - {1'b0, req.b};
        end
        else
        begin
            sum = {1'b0, req.a} + {1'b0, req.b};
        end
        rsp.res   = sum[31:0];
        rsp.carry = sum[32];
        rsp.zero  = (sum[31:0] == 32'd0);
    end

endmodule

[rtl/alm_entry_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alm_entry_mem: alarm entry store
// One write port and one read port with registered read data. Contents are
// undefined until written.
// ----------------------------------------------------------------------------
module alm_entry_mem #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  alm_pkg::entry_t  wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output alm_pkg::entry_t  rd_data
);

    alm_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/alarm_table_and_countdown_timer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alarm_table_and_countdown_timer: alarm table with ring cadence and timer
// A small sequencer shares one adder and an entry store with a read and a write
// port; a tick checks ring age and timeout, timer expiry, then walks the table.
// ----------------------------------------------------------------------------
//  Channel  Dir  Signals                      Payload
//  s_       in   tvalid tready tdata tuser    tuser: command; tdata: time, index
//  m_       out  tvalid tready tdata          status after the item
//
//  A tick checks the ring age while ringing and the timer while it runs, then
//  walks the table, reading one entry per cycle from the store. Delete copies
//  each entry above the deleted one down by one place; toggle reads the entry
//  and writes it back. s_tready is high only while idle. The result sits in an
//  output register, so a new item is taken while it waits; a stalled result
//  holds the sequencer in its final state. Reset clears the control state at
//  once and needs no clearing pass.
// ----------------------------------------------------------------------------
module alarm_table_and_countdown_timer #(
    parameter int MAX_ENTRIES      = 8,
    parameter int TICKS_PER_SECOND = 60
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [31:0] now_ticks, [36:32] clock_hour, [42:37] clock_minute,
    // [48:43] clock_second, [51:49] entry_index, [55:52] zero
    input  logic [55:0] s_tdata,
    // [3:0] command
    input  logic [3:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] ringing_now, [1] beep_request, [2] sound_off, [6:3] entry_total,
    // [7] timer_active, [23:8] timer_duration
    output logic [23:0] m_tdata
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int IW = (CW > 3) ? CW : 3;
    localparam int TW = $clog2(TICKS_PER_SECOND + 1);
    localparam int LW = 16 + TW;
    localparam logic [TW-1:0] TPS_C = TW'(TICKS_PER_SECOND);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_ENTRIES);

    // The beep is on for the first half of each 20-tick period. The age is
    // split as 4 * (age >> 2) + age[1:0]; (age >> 2) mod 5 follows from the
    // sum of its nibbles, since 16 is one modulo 5.
    function automatic logic beep_phase(input logic [31:0] age);
        logic [6:0] s;
        logic [4:0] t;
        logic [2:0] r;
        s = {5'd0, age[31:30]};
        for (int k = 0; k < 7; k++)
        begin
            s = s + {3'd0, age[2 + 4 * k +: 4]};
        end
        t = {2'd0, s[6:4]} + {1'b0, s[3:0]};
        if (t >= 5'd20)
        begin
            t = t - 5'd20;
        end
        if (t >= 5'd10)
        begin
            t = t - 5'd10;
        end
        if (t >= 5'd5)
        begin
            t = t - 5'd5;
        end
        r = t[2:0];
        return (r < 3'd2) || ((r == 3'd2) && !age[1]);
    endfunction

    alm_pkg::state_t state_reg, state_next;
    alm_pkg::cmd_t   cmd_reg, cmd_next;
    logic [31:0]     now_reg, now_next;
    logic [4:0]      hour_reg, hour_next;
    logic [5:0]      min_reg, min_next;
    logic [5:0]      sec_reg, sec_next;
    logic [2:0]      idx_reg, idx_next;

    logic [CW-1:0]   count_reg, count_next;
    logic            ring_reg, ring_next;
    logic [31:0]     ring_begin_reg, ring_begin_next;
    logic            timer_reg, timer_next;
    logic [31:0]     timer_begin_reg, timer_begin_next;
    logic [15:0]     dur_reg, dur_next;

    logic            beep_reg, beep_next;
    logic            off_reg, off_next;
    logic [31:0]     diff_reg, diff_next;
    logic [LW-1:0]   limit_reg, limit_next;
    logic [CW-1:0]   walk_reg, walk_next;
    logic            pipe_vld_reg, pipe_vld_next;
    logic [AW-1:0]   pipe_idx_reg, pipe_idx_next;

    logic            m_valid_reg, m_valid_next;
    logic [23:0]     m_data_reg, m_data_next;

    alm_pkg::alu_req_t alu_req;
    alm_pkg::alu_rsp_t alu_rsp;

    logic            mem_wr_en;
    logic [AW-1:0]   mem_wr_addr;
    alm_pkg::entry_t mem_wr_data;
    logic            mem_rd_en;
    logic [AW-1:0]   mem_rd_addr;
    alm_pkg::entry_t mem_rd_data;

    logic [IW-1:0]   idx_w;
    logic            idx_ok;
    logic            match;
    logic            fire;

    alm_alu u_alu
    (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    alm_entry_mem #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_mem
    (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign s_tready = (state_reg == alm_pkg::S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign idx_w  = IW'(idx_reg);
    assign idx_ok = idx_w < IW'(count_reg);
    assign match  = alu_rsp.zero;
    assign fire   = mem_rd_data.enabled && !mem_rd_data.latched && match
                    && (sec_reg[5:1] == 5'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= alm_pkg::S_IDLE;
            count_reg       <= '0;
            ring_reg        <= 1'b0;
            ring_begin_reg  <= 32'd0;
            timer_reg       <= 1'b0;
            timer_begin_reg <= 32'd0;
            dur_reg         <= alm_pkg::DUR_RESET;
            walk_reg        <= '0;
            pipe_vld_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            ring_reg        <= ring_next;
            ring_begin_reg  <= ring_begin_next;
            timer_reg       <= timer_next;
            timer_begin_reg <= timer_begin_next;
            dur_reg         <= dur_next;
            walk_reg        <= walk_next;
            pipe_vld_reg    <= pipe_vld_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        now_reg      <= now_next;
        hour_reg     <= hour_next;
        min_reg      <= min_next;
        sec_reg      <= sec_next;
        idx_reg      <= idx_next;
        beep_reg     <= beep_next;
        off_reg      <= off_next;
        diff_reg     <= diff_next;
        limit_reg    <= limit_next;
        pipe_idx_reg <= pipe_idx_next;
        m_data_reg   <= m_data_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        now_next         = now_reg;
        hour_next        = hour_reg;
        min_next         = min_reg;
        sec_next         = sec_reg;
        idx_next         = idx_reg;
        count_next       = count_reg;
        ring_next        = ring_reg;
        ring_begin_next  = ring_begin_reg;
        timer_next       = timer_reg;
        timer_begin_next = timer_begin_reg;
        dur_next         = dur_reg;
        beep_next        = beep_reg;
        off_next         = off_reg;
        diff_next        = diff_reg;
        limit_next       = limit_reg;
        walk_next        = walk_reg;
        pipe_vld_next    = pipe_vld_reg;
        pipe_idx_next    = pipe_idx_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_data_next      = m_data_reg;

        alu_req.op  = alm_pkg::ALU_SUB;
        alu_req.a   = 32'd0;
        alu_req.b   = 32'd0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = '0;
        mem_wr_data = '0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;

        unique case (state_reg)
            alm_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next   = alm_pkg::cmd_t'(s_tuser);
                    now_next   = s_tdata[31:0];
                    hour_next  = s_tdata[36:32];
                    min_next   = s_tdata[42:37];
                    sec_next   = s_tdata[48:43];
                    idx_next   = s_tdata[51:49];
                    state_next = alm_pkg::S_DISPATCH;
                end
            end

            alm_pkg::S_DISPATCH:
            begin
                beep_next  = 1'b0;
                off_next   = 1'b0;
                state_next = alm_pkg::S_DONE;
                case (cmd_reg)
                    alm_pkg::CMD_TICK:
                    begin
                        limit_next = LW'(dur_reg) * LW'(TPS_C);
                        alu_req.a  = now_reg;
                        alu_req.b  = ring_begin_reg;
                        diff_next  = alu_rsp.res;
                        state_next = ring_reg ? alm_pkg::S_RING_CHK
                                              : alm_pkg::S_TMR_AGE;
                    end
                    alm_pkg::CMD_ADD:
                    begin
                        if (count_reg < MAX_C)
                        begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = count_reg[AW-1:0];
                            mem_wr_data = '{hour: hour_reg, minute: min_reg,
                                            enabled: 1'b1, latched: 1'b0};
                            count_next  = count_reg + CW'(1);
                        end
                    end
                    alm_pkg::CMD_TOGGLE:
                    begin
                        if (idx_ok)
                        begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = AW'(idx_w);
                            state_next  = alm_pkg::S_TOGGLE_WR;
                        end
                    end
                    alm_pkg::CMD_DELETE:
                    begin
                        if (idx_ok)
                        begin
                            walk_next     = CW'(idx_w) + CW'(1);
                            pipe_vld_next = 1'b0;
                            state_next    = alm_pkg::S_DELETE;
                        end
                    end
                    alm_pkg::CMD_STOP_RING:
                    begin
                        if (ring_reg)
                        begin
                            ring_next = 1'b0;
                            off_next  = 1'b1;
                        end
                    end
                    alm_pkg::CMD_TIMER_TGL:
                    begin
                        if (timer_reg)
                        begin
                            timer_next = 1'b0;
                        end
                        else
                        begin
                            timer_next       = 1'b1;
                            timer_begin_next = now_reg;
                        end
                    end
                    alm_pkg::CMD_TIMER_RST:
                    begin
                        timer_next = 1'b0;
                    end
                    alm_pkg::CMD_PLUS_MIN:
                    begin
                        alu_req.op = alm_pkg::ALU_ADD;
                        alu_req.a  = {16'd0, dur_reg};
                        alu_req.b  = {16'd0, alm_pkg::STEP_SECONDS};
                        dur_next   = (|alu_rsp.res[31:16]) ? alm_pkg::DUR_MAX
                                                           : alu_rsp.res[15:0];
                    end
                    alm_pkg::CMD_MINUS_MIN:
                    begin
                        alu_req.a = {16'd0, dur_reg};
                        alu_req.b = {16'd0, alm_pkg::STEP_SECONDS};
                        // Only while the duration is above one minute.
                        if (!alu_rsp.carry && !alu_rsp.zero)
                        begin
                            dur_next = alu_rsp.res[15:0];
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            alm_pkg::S_RING_CHK:
            begin
                beep_next = beep_phase(diff_reg);
                alu_req.a = diff_reg;
                alu_req.b = alm_pkg::RING_TIMEOUT + 32'd1;
                if (!alu_rsp.carry)
                begin
                    ring_next = 1'b0;
                    off_next  = 1'b1;
                end
                state_next = alm_pkg::S_TMR_AGE;
            end

            alm_pkg::S_TMR_AGE:
            begin
                alu_req.a     = now_reg;
                alu_req.b     = timer_begin_reg;
                diff_next     = alu_rsp.res;
                walk_next     = '0;
                pipe_vld_next = 1'b0;
                state_next    = timer_reg ? alm_pkg::S_TMR_CHK : alm_pkg::S_WALK;
            end

            alm_pkg::S_TMR_CHK:
            begin
                alu_req.a = diff_reg;
                alu_req.b = 32'(limit_reg);
                if (!alu_rsp.carry)
                begin
                    timer_next      = 1'b0;
                    ring_next       = 1'b1;
                    ring_begin_next = now_reg;
                end
                state_next = alm_pkg::S_WALK;
            end

            alm_pkg::S_WALK:
            begin
                // Read of the next entry overlaps the update of the previous.
                if (walk_reg < count_reg)
                begin
                    mem_rd_en     = 1'b1;
                    mem_rd_addr   = walk_reg[AW-1:0];
                    pipe_idx_next = walk_reg[AW-1:0];
                    pipe_vld_next = 1'b1;
                    walk_next     = walk_reg + CW'(1);
                end
                else
                begin
                    pipe_vld_next = 1'b0;
                end
                if (pipe_vld_reg)
                begin
                    alu_req.a   = {21'd0, mem_rd_data.hour, mem_rd_data.minute};
                    alu_req.b   = {21'd0, hour_reg, min_reg};
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = pipe_idx_reg;
                    mem_wr_data = mem_rd_data;
                    mem_wr_data.latched = match && (mem_rd_data.latched || fire);
                    if (fire)
                    begin
                        ring_next       = 1'b1;
                        ring_begin_next = now_reg;
                    end
                end
                if ((walk_reg == count_reg) && !pipe_vld_reg)
                begin
                    state_next = alm_pkg::S_DONE;
                end
            end

            alm_pkg::S_TOGGLE_WR:
            begin
                mem_wr_en           = 1'b1;
                mem_wr_addr         = AW'(idx_w);
                mem_wr_data         = mem_rd_data;
                mem_wr_data.enabled = !mem_rd_data.enabled;
                state_next          = alm_pkg::S_DONE;
            end

            alm_pkg::S_DELETE:
            begin
                if (walk_reg < count_reg)
                begin
                    mem_rd_en     = 1'b1;
                    mem_rd_addr   = walk_reg[AW-1:0];
                    pipe_idx_next = AW'(walk_reg - CW'(1));
                    pipe_vld_next = 1'b1;
                    walk_next     = walk_reg + CW'(1);
                end
                else
                begin
                    pipe_vld_next = 1'b0;
                end
                if (pipe_vld_reg)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = pipe_idx_reg;
                    mem_wr_data = mem_rd_data;
                end
                if ((walk_reg == count_reg) && !pipe_vld_reg)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = alm_pkg::S_DONE;
                end
            end

            alm_pkg::S_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {dur_reg, timer_reg, 4'(count_reg),
                                    off_reg, beep_reg, ring_reg};
                    state_next   = alm_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = alm_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[dv/tb_alarm_table_and_countdown_timer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_alarm_table_and_countdown_timer: self-checking bench of the alarm block
// Drives ticks and user commands into the input stream and mirrors the alarm
// table, ring cadence and countdown timer in a scoreboard. Every status item
// on the output stream is checked in order against the mirrored state. Both
// streams idle at random, with one long output stall and two full drains.
// ----------------------------------------------------------------------------
module tb_alarm_table_and_countdown_timer;

    localparam int          TABLE_DEPTH   = 8;
    localparam int          TICKS_PER_SEC = 60;
    localparam logic [31:0] BEEP_PERIOD   = 32'd20;
    localparam logic [31:0] BEEP_ON       = 32'd10;
    localparam int          CYCLE_LIMIT   = 1500000;
    localparam int          TAIL_CYCLES   = 40;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          HOLD_AFTER    = 250;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic [3:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    // calm and items_in are shared between the two stream processes.
    bit          calm;
    int          items_in;
    int          cycle_count;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrored alarm state and the queue of awaited status items.
    // ------------------------------------------------------------------------
    class alarm_scoreboard;
        alm_pkg::entry_t tbl [TABLE_DEPTH];
        logic [3:0]  cnt;
        logic        ringing;
        logic [31:0] ring_t0;
        logic        timer_on;
        logic [31:0] timer_t0;
        logic [15:0] dur;
        logic [23:0] status_q [$];
        int          mismatches;
        int          failures;

        function new();
            cnt        = '0;
            ringing    = 1'b0;
            ring_t0    = '0;
            timer_on   = 1'b0;
            timer_t0   = '0;
            dur        = alm_pkg::DUR_RESET;
            mismatches = 0;
            failures   = 0;
            for (int i = 0; i < TABLE_DEPTH; i++)
                tbl[i] = '0;
        endfunction

        function int pending();
            return status_q.size();
        endfunction

        function void do_tick(logic [31:0] now, logic [4:0] hr, logic [5:0] mn,
                              logic [5:0] sc, output logic beep, output logic off);
            logic [31:0] age;
            logic [31:0] limit;
            logic        same;
            beep = 1'b0;
            off  = 1'b0;
            if (ringing)
            begin
                age = now - ring_t0;
                if ((age % BEEP_PERIOD) < BEEP_ON)
                    beep = 1'b1;
                if (age > alm_pkg::RING_TIMEOUT)
                begin
                    ringing = 1'b0;
                    off     = 1'b1;
                end
            end
            if (timer_on)
            begin
                limit = {16'd0, dur} * TICKS_PER_SEC;
                if ((now - timer_t0) >= limit)
                begin
                    timer_on = 1'b0;
                    ringing  = 1'b1;
                    ring_t0  = now;
                end
            end
            for (int i = 0; i < cnt; i++)
            begin
                same = (tbl[i].hour == hr) && (tbl[i].minute == mn);
                if (tbl[i].enabled && !tbl[i].latched && same && sc < 6'd2)
                begin
                    ringing        = 1'b1;
                    ring_t0        = now;
                    tbl[i].latched = 1'b1;
                end
                if (tbl[i].latched && !same)
                    tbl[i].latched = 1'b0;
            end
        endfunction

        // Applies one accepted item and queues the status it must produce.
        function void note_item(logic [3:0] cmd, logic [55:0] data);
            logic [31:0] now;
            logic [4:0]  hr;
            logic [5:0]  mn;
            logic [5:0]  sc;
            logic [2:0]  idx;
            logic        beep;
            logic        off;
            logic [16:0] sum;
            now  = data[31:0];
            hr   = data[36:32];
            mn   = data[42:37];
            sc   = data[48:43];
            idx  = data[51:49];
            beep = 1'b0;
            off  = 1'b0;
            case (cmd)
                alm_pkg::CMD_TICK:
                    do_tick(now, hr, mn, sc, beep, off);
                alm_pkg::CMD_ADD:
                    if (cnt < TABLE_DEPTH)
                    begin
                        tbl[cnt] = '{hour: hr, minute: mn, enabled: 1'b1, latched: 1'b0};
                        cnt      = cnt + 4'd1;
                    end
                alm_pkg::CMD_TOGGLE:
                    if ({1'b0, idx} < cnt)
                        tbl[idx].enabled = !tbl[idx].enabled;
                alm_pkg::CMD_DELETE:
                    if ({1'b0, idx} < cnt)
                    begin
                        for (int j = int'(idx); j + 1 < cnt; j++)
                            tbl[j] = tbl[j + 1];
                        cnt = cnt - 4'd1;
                    end
                alm_pkg::CMD_STOP_RING:
                    if (ringing)
                    begin
                        ringing = 1'b0;
                        off     = 1'b1;
                    end
                alm_pkg::CMD_TIMER_TGL:
                    if (timer_on)
                        timer_on = 1'b0;
                    else
                    begin
                        timer_on = 1'b1;
                        timer_t0 = now;
                    end
                alm_pkg::CMD_TIMER_RST:
                    timer_on = 1'b0;
                alm_pkg::CMD_PLUS_MIN:
                begin
                    sum = {1'b0, dur} + {1'b0, alm_pkg::STEP_SECONDS};
                    dur = sum[16] ? alm_pkg::DUR_MAX : sum[15:0];
                end
                alm_pkg::CMD_MINUS_MIN:
                    if (dur > alm_pkg::STEP_SECONDS)
                        dur = dur - alm_pkg::STEP_SECONDS;
                default:
                    ;
            endcase
            status_q.push_back({dur, timer_on, cnt, off, beep, ringing});
        endfunction

        function void check_result(logic [23:0] got);
            logic [23:0] want;
            if (status_q.size() == 0)
            begin
                failures++;
                if (mismatches + failures <= 10)
                    $display("unexpected status item %h", got);
                return;
            end
            want = status_q.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches + failures <= 10)
                    $display({"status mismatch (exp/act): ring %0d/%0d beep %0d/%0d ",
                              "off %0d/%0d count %0d/%0d timer %0d/%0d dur %0d/%0d"},
                             want[0], got[0], want[1], got[1], want[2], got[2],
                             want[6:3], got[6:3], want[7], got[7],
                             want[23:8], got[23:8]);
            end
        endfunction
    endclass

    alarm_scoreboard sb;

    alarm_table_and_countdown_timer DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [55:0] pack_item(logic [31:0] now, logic [4:0] hr,
                                              logic [5:0] mn, logic [5:0] sc,
                                              logic [2:0] idx);
        return {4'd0, idx, sc, mn, hr, now};
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(logic [3:0] cmd, logic [55:0] data);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_item(cmd, data);
        items_in++;
        @(negedge clk);
    endtask

    task automatic idle_input();
        int gap;
        if (!calm && $urandom_range(0, 99) < 40)
        begin
            gap = pick_gap();
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    logic [31:0] tick_now;

    // One random item: ticks, often at the stored alarm times, and commands; plus_only sends only CMD_PLUS_MIN.
    task automatic random_item(bit plus_only);
        int          r;
        int          k;
        logic [3:0]  cmd;
        logic [4:0]  hr;
        logic [5:0]  mn;
        logic [5:0]  sc;
        logic [2:0]  idx;
        r   = $urandom_range(0, 99);
        hr  = 5'($urandom_range(0, 31));
        mn  = 6'($urandom_range(0, 63));
        sc  = 6'($urandom_range(0, 63));
        idx = 3'($urandom_range(0, 7));
        if (plus_only)
            cmd = alm_pkg::CMD_PLUS_MIN;
        else if (r < 45)
            cmd = alm_pkg::CMD_TICK;
        else if (r < 56)
            cmd = alm_pkg::CMD_ADD;
        else if (r < 63)
            cmd = alm_pkg::CMD_TOGGLE;
        else if (r < 70)
            cmd = alm_pkg::CMD_DELETE;
        else if (r < 75)
            cmd = alm_pkg::CMD_STOP_RING;
        else if (r < 82)
            cmd = alm_pkg::CMD_TIMER_TGL;
        else if (r < 85)
            cmd = alm_pkg::CMD_TIMER_RST;
        else if (r < 91)
            cmd = alm_pkg::CMD_PLUS_MIN;
        else if (r < 97)
            cmd = alm_pkg::CMD_MINUS_MIN;
        else
            cmd = 4'($urandom_range(9, 15));

        if (cmd == alm_pkg::CMD_TICK)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                tick_now = tick_now + $urandom_range(1, 25);
            else if (r < 90)
                tick_now = tick_now + $urandom_range(26, 400);
            else if (r < 98)
                tick_now = tick_now + $urandom_range(401, 40000);
            else
                tick_now = $urandom;
            if (sb.cnt != 0 && $urandom_range(0, 99) < 45)
            begin
                k  = $urandom_range(0, sb.cnt - 1);
                hr = sb.tbl[k].hour;
                mn = sb.tbl[k].minute;
                sc = 6'($urandom_range(0, 3));
            end
            else if ($urandom_range(0, 99) < 70)
            begin
                hr = 5'($urandom_range(0, 23));
                mn = 6'($urandom_range(0, 59));
                sc = 6'($urandom_range(0, 59));
            end
        end
        else if (cmd == alm_pkg::CMD_ADD)
        begin
            if ($urandom_range(0, 99) < 85)
                hr = 5'($urandom_range(0, 23));
            if ($urandom_range(0, 99) < 85)
                mn = 6'($urandom_range(0, 59));
        end
        else if ((cmd == alm_pkg::CMD_TOGGLE || cmd == alm_pkg::CMD_DELETE)
                 && sb.cnt != 0 && $urandom_range(0, 99) < 80)
            idx = 3'($urandom_range(0, sb.cnt - 1));

        if ($urandom_range(0, 99) < 2)
            calm = !calm;
        send_item(cmd, pack_item(tick_now, hr, mn, sc, idx));
        idle_input();
    endtask

    // Output side: random back-pressure and one long hold-off.
    initial
    begin
        int  rx_gap;
        int  hold_left;
        bit  held;
        rx_gap    = 0;
        hold_left = 0;
        held      = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready  <= 1'b0;
                hold_left = hold_left - 1;
            end
            else if (!held && items_in >= HOLD_AFTER)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_tready  <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                m_tready <= 1'b0;
                rx_gap   = rx_gap - 1;
            end
            else if (calm || $urandom_range(0, 99) < 70)
                m_tready <= 1'b1;
            else
            begin
                rx_gap   = pick_gap() - 1;
                m_tready <= 1'b0;
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        sb       = new();
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;
        calm     = 1'b0;
        items_in = 0;
        tick_now = 32'd1000;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: floor of the duration, empty-table commands, field extremes.
        send_item(alm_pkg::CMD_MINUS_MIN, pack_item(32'd0, 5'd0, 6'd0, 6'd0, 3'd0));
        send_item(alm_pkg::CMD_STOP_RING, pack_item(32'd0, 5'd0, 6'd0, 6'd0, 3'd0));
        send_item(alm_pkg::CMD_TOGGLE, pack_item(32'd0, 5'd0, 6'd0, 6'd0, 3'd0));
        send_item(alm_pkg::CMD_DELETE, pack_item(32'd0, 5'd0, 6'd0, 6'd0, 3'd7));
        send_item(alm_pkg::CMD_TICK, pack_item(32'd0, 5'd0, 6'd0, 6'd0, 3'd0));
        send_item(4'd15, pack_item(32'hFFFF_FFFF, 5'd31, 6'd63, 6'd63, 3'd7));
        send_item(4'd9, pack_item(32'h5555_5555, 5'd21, 6'd42, 6'd21, 3'd5));
        // Fill the table, one entry out of the clock's range, then one too many.
        send_item(alm_pkg::CMD_ADD, pack_item(32'd0, 5'd0, 6'd0, 6'd0, 3'd0));
        send_item(alm_pkg::CMD_ADD, pack_item(32'd0, 5'd23, 6'd59, 6'd0, 3'd0));
        send_item(alm_pkg::CMD_ADD, pack_item(32'd0, 5'd31, 6'd63, 6'd0, 3'd0));
        for (int i = 0; i < 6; i++)
            send_item(alm_pkg::CMD_ADD, pack_item(32'd0, 5'd12, 6'd30, 6'd0, 3'd0));
        // Match, repeat while latched, cadence off phase, then the ring timeout.
        send_item(alm_pkg::CMD_TICK, pack_item(32'd100, 5'd23, 6'd59, 6'd1, 3'd0));
        send_item(alm_pkg::CMD_TICK, pack_item(32'd105, 5'd23, 6'd59, 6'd0, 3'd0));
        send_item(alm_pkg::CMD_TICK, pack_item(32'd115, 5'd23, 6'd59, 6'd5, 3'd0));
        send_item(alm_pkg::CMD_TICK, pack_item(32'd500, 5'd0, 6'd0, 6'd30, 3'd0));
        send_item(alm_pkg::CMD_TOGGLE, pack_item(32'd0, 5'd0, 6'd0, 6'd0, 3'd0));
        send_item(alm_pkg::CMD_DELETE, pack_item(32'd0, 5'd0, 6'd0, 6'd0, 3'd0));
        send_item(alm_pkg::CMD_DELETE, pack_item(32'd0, 5'd0, 6'd0, 6'd0, 3'd6));
        // Timer expiry across the wrap of the tick counter, then stop the ring.
        send_item(alm_pkg::CMD_TIMER_TGL,
                  pack_item(32'hFFFF_FF00, 5'd0, 6'd0, 6'd0, 3'd0));
        send_item(alm_pkg::CMD_PLUS_MIN, pack_item(32'd0, 5'd0, 6'd0, 6'd0, 3'd0));
        send_item(alm_pkg::CMD_TICK,
                  pack_item(32'hFFFF_FF00 + 32'd7200, 5'd5, 6'd5, 6'd30, 3'd0));
        send_item(alm_pkg::CMD_STOP_RING, pack_item(32'd0, 5'd0, 6'd0, 6'd0, 3'd0));
        send_item(alm_pkg::CMD_TIMER_RST, pack_item(32'd0, 5'd0, 6'd0, 6'd0, 3'd0));

        for (int n = 0; n < 600; n++)
            random_item(1'b0);
        drain();
        @(negedge clk);
        // Run the duration into saturation, then mix again from there.
        for (int n = 0; n < 1100; n++)
            random_item(1'b1);
        for (int n = 0; n < 220; n++)
            random_item(1'b0);

        drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        sb.failures = sb.failures + sb.pending();
        if (sb.mismatches == 0 && sb.failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[sim.f]
rtl/alm_pkg.sv
rtl/alm_alu.sv
rtl/alm_entry_mem.sv
rtl/alarm_table_and_countdown_timer.sv
dv/tb_alarm_table_and_countdown_timer.sv
